>>> src/mctu_pkg.sv
`timescale 1ns / 1ps

package mctu_pkg;

  // Number of terminal channels in the row of cells.
  localparam int unsigned NumChannels = 8;
  localparam int unsigned CellIdxW    = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  // Field widths.
  localparam int unsigned OpW      = 3;
  localparam int unsigned ChanW    = 3;
  localparam int unsigned OffW     = 3;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LevelW   = 3;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CmpW     = (ChanW > CellIdxW) ? ChanW : CellIdxW;

  // Operation codes.
  localparam logic [OpW-1:0] OpConnect    = 3'd0;
  localparam logic [OpW-1:0] OpHostByte   = 3'd1;
  localparam logic [OpW-1:0] OpDisconnect = 3'd2;
  localparam logic [OpW-1:0] OpBusRead    = 3'd3;
  localparam logic [OpW-1:0] OpBusWrite   = 3'd4;
  localparam logic [OpW-1:0] OpIrqAck     = 3'd5;

  // Register offsets in a channel window.
  localparam logic [OffW-1:0] OffStatus = 3'd0;
  localparam logic [OffW-1:0] OffRxData = 3'd2;
  localparam logic [OffW-1:0] OffTx     = 3'd4;

  // Status bits and characters.
  localparam logic [ByteW-1:0] StRxReady = 8'h01;
  localparam logic [ByteW-1:0] StAlways  = 8'h02;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;

  // Configuration registers.
  localparam logic [CfgIdxW-1:0] RegIrqLevel   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegVectorBase = 8'd1;
  localparam logic [LevelW-1:0]  IrqLevelReset   = 3'd4;
  localparam logic [ByteW-1:0]   VectorBaseReset = 8'd70;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [ChanW-1:0]  channel;
    logic [OffW-1:0]   reg_offset;
    logic [ByteW-1:0]  data_byte;
    logic [LevelW-1:0] ack_level;
  } req_t;

  // Information passed from one cell to the next along the row.
  typedef struct packed {
    logic                free_seen;
    logic                ready_seen;
    logic                ready_next_any;
    logic                accepted;
    logic                connect_hit;
    logic [ChanW-1:0]    assigned;
    logic [ByteW-1:0]    read_data;
    logic                tx_valid;
    logic                ack_hit;
    logic [CellIdxW-1:0] ack_chan;
  } link_t;

endpackage

>>> src/mctu_if.sv
`timescale 1ns / 1ps

interface mctu_req_if import mctu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [ChanW-1:0]  channel;
  logic [OffW-1:0]   reg_offset;
  logic [ByteW-1:0]  data_byte;
  logic [LevelW-1:0] ack_level;

  modport source (output valid, op, channel, reg_offset, data_byte, ack_level,
                  input ready);
  modport sink (input valid, op, channel, reg_offset, data_byte, ack_level,
                output ready);
endinterface

interface mctu_rsp_if import mctu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  read_data;
  logic              accepted;
  logic [ChanW-1:0]  assigned_channel;
  logic              lines_busy;
  logic              tx_valid;
  logic [ByteW-1:0]  tx_byte;
  logic [ChanW-1:0]  tx_channel;
  logic [LevelW-1:0] irq_line;
  logic [ByteW-1:0]  ack_vector;
  logic              ack_autovector;

  modport source (output valid, read_data, accepted, assigned_channel, lines_busy,
                  tx_valid, tx_byte, tx_channel, irq_line, ack_vector,
                  ack_autovector, input ready);
  modport sink (input valid, read_data, accepted, assigned_channel, lines_busy,
                tx_valid, tx_byte, tx_channel, irq_line, ack_vector,
                ack_autovector, output ready);
endinterface

interface mctu_cfg_if import mctu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/mctu_cell.sv
`timescale 1ns / 1ps

module mctu_cell import mctu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CellIdxW-1:0] cell_idx_i,
  input  logic                go_i,
  input  req_t                req_i,
  input  link_t               link_i,
  output link_t               link_o
);

  logic             conn_q, conn_d;
  logic             rdy_q, rdy_d;
  logic             cr_q, cr_d;
  logic [ByteW-1:0] latch_q, latch_d;
  logic             sel;

  assign sel = go_i && (CmpW'(req_i.channel) == CmpW'(cell_idx_i));

  always_comb begin
    conn_d  = conn_q;
    rdy_d   = rdy_q;
    cr_d    = cr_q;
    latch_d = latch_q;
    link_o  = link_i;

    // Lowest free channel wins a connect request.
    link_o.free_seen = link_i.free_seen | ~conn_q;
    if (go_i && req_i.op == OpConnect && !conn_q && !link_i.free_seen) begin
      conn_d             = 1'b1;
      cr_d               = 1'b0;
      link_o.connect_hit = 1'b1;
      link_o.assigned    = ChanW'(cell_idx_i);
    end

    // Lowest channel holding an unread byte answers an acknowledge.
    link_o.ready_seen = link_i.ready_seen | rdy_q;
    if (rdy_q && !link_i.ready_seen) begin
      link_o.ack_hit  = 1'b1;
      link_o.ack_chan = cell_idx_i;
    end

    if (sel) begin
      case (req_i.op)
        OpHostByte: begin
          if (conn_q && !rdy_q) begin
            link_o.accepted = 1'b1;
            if (req_i.data_byte == ChLf && cr_q) begin
              cr_d = 1'b0;
            end else begin
              cr_d    = (req_i.data_byte == ChCr);
              latch_d = req_i.data_byte;
              rdy_d   = 1'b1;
            end
          end
        end
        OpDisconnect: begin
          conn_d = 1'b0;
          rdy_d  = 1'b0;
          cr_d   = 1'b0;
        end
        OpBusRead: begin
          if (req_i.reg_offset == OffStatus) begin
            link_o.read_data = link_i.read_data | StAlways | (rdy_q ? StRxReady : '0);
          end else if (req_i.reg_offset == OffRxData) begin
            link_o.read_data = link_i.read_data | latch_q;
            rdy_d            = 1'b0;
          end
        end
        OpBusWrite: begin
          if (req_i.reg_offset == OffTx && conn_q) begin
            link_o.tx_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    link_o.ready_next_any = link_i.ready_next_any | rdy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q  <= 1'b0;
      rdy_q   <= 1'b0;
      cr_q    <= 1'b0;
      latch_q <= '0;
    end else if (go_i) begin
      conn_q  <= conn_d;
      rdy_q   <= rdy_d;
      cr_q    <= cr_d;
      latch_q <= latch_d;
    end
  end

endmodule

>>> src/mctu_chain.sv
`timescale 1ns / 1ps

module mctu_chain import mctu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  go_i,
  input  req_t  req_i,
  output link_t link_o
);

  link_t links [NumChannels+1];

  assign links[0] = '0;

  for (genvar i = 0; i < NumChannels; i++) begin : g_cell
    mctu_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CellIdxW'(i)),
      .go_i       (go_i),
      .req_i      (req_i),
      .link_i     (links[i]),
      .link_o     (links[i+1])
    );
  end

  assign link_o = links[NumChannels];

endmodule

>>> src/multi_channel_terminal_uart_top.sv
`timescale 1ns / 1ps

// Multi-channel terminal receiver/transmitter.
// Requests arrive on req_i (valid/ready): connect, host byte, disconnect, bus
// read, bus write or interrupt acknowledge. Each request produces exactly one
// response on rsp_o (valid/ready), in the cycle after it is accepted.
// The channels form a row of identical cells; each cell keeps one channel's
// connected flag, receive latch, ready flag and CR memory, and passes the
// lowest-free and lowest-ready searches and its response bits on to the next
// cell within the cycle.
// Throughput is one request per cycle while the response is taken; the
// single response register sets that figure. When the receiver stalls, the
// response is held and req_i.ready drops until it has been taken.
// Configuration writes on cfg_i set the shared interrupt level (index 0) and
// the vector base (index 1); cfg_i is always ready and should only be written
// while no response is outstanding.
// After reset all channels are free and empty, the level is 4 and the vector
// base is 70.

module multi_channel_terminal_uart_top import mctu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mctu_req_if.sink    req_i,
  mctu_rsp_if.source  rsp_o,
  mctu_cfg_if.sink    cfg_i
);

  logic [LevelW-1:0] irq_level_q;
  logic [ByteW-1:0]  vector_base_q;
  logic              rsp_valid_q;
  logic              go;
  req_t              req;
  link_t             res;

  logic [ByteW-1:0]  read_data_q, read_data_d;
  logic              accepted_q, accepted_d;
  logic [ChanW-1:0]  assigned_q, assigned_d;
  logic              busy_q, busy_d;
  logic              tx_valid_q, tx_valid_d;
  logic [ByteW-1:0]  tx_byte_q, tx_byte_d;
  logic [ChanW-1:0]  tx_channel_q, tx_channel_d;
  logic [LevelW-1:0] irq_line_q, irq_line_d;
  logic [ByteW-1:0]  ack_vector_q, ack_vector_d;
  logic              autovec_q, autovec_d;

  // A new request is taken whenever the response register is empty or is
  // being emptied in the same cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign go          = req_i.valid && req_i.ready;

  assign req.op         = req_i.op;
  assign req.channel    = req_i.channel;
  assign req.reg_offset = req_i.reg_offset;
  assign req.data_byte  = req_i.data_byte;
  assign req.ack_level  = req_i.ack_level;

  mctu_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (req),
    .link_o (res)
  );

  // Assemble the response from what the row of cells has gathered.
  always_comb begin
    read_data_d  = (req.op == OpBusRead) ? res.read_data : '0;
    accepted_d   = (req.op == OpHostByte) && res.accepted;
    assigned_d   = (req.op == OpConnect) ? res.assigned : '0;
    busy_d       = (req.op == OpConnect) && !res.connect_hit;
    tx_valid_d   = (req.op == OpBusWrite) && res.tx_valid;
    tx_byte_d    = tx_valid_d ? req.data_byte : '0;
    tx_channel_d = tx_valid_d ? req.channel : '0;
    irq_line_d   = res.ready_next_any ? irq_level_q : '0;
    ack_vector_d = '0;
    autovec_d    = 1'b0;
    if (req.op == OpIrqAck) begin
      if (res.ack_hit && req.ack_level == irq_level_q) begin
        ack_vector_d = vector_base_q + ByteW'(res.ack_chan);
      end else begin
        autovec_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (go) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      read_data_q  <= read_data_d;
      accepted_q   <= accepted_d;
      assigned_q   <= assigned_d;
      busy_q       <= busy_d;
      tx_valid_q   <= tx_valid_d;
      tx_byte_q    <= tx_byte_d;
      tx_channel_q <= tx_channel_d;
      irq_line_q   <= irq_line_d;
      ack_vector_q <= ack_vector_d;
      autovec_q    <= autovec_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.read_data        = read_data_q;
  assign rsp_o.accepted         = accepted_q;
  assign rsp_o.assigned_channel = assigned_q;
  assign rsp_o.lines_busy       = busy_q;
  assign rsp_o.tx_valid         = tx_valid_q;
  assign rsp_o.tx_byte          = tx_byte_q;
  assign rsp_o.tx_channel       = tx_channel_q;
  assign rsp_o.irq_line         = irq_line_q;
  assign rsp_o.ack_vector       = ack_vector_q;
  assign rsp_o.ack_autovector   = autovec_q;

  // Configuration registers; writes to unknown indexes are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_level_q   <= IrqLevelReset;
      vector_base_q <= VectorBaseReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegIrqLevel) begin
        irq_level_q <= LevelW'(cfg_i.data);
      end else if (cfg_i.index == RegVectorBase) begin
        vector_base_q <= cfg_i.data;
      end
    end
  end

  // Every accepted request leaves a response behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni) go |=> rsp_valid_q)
    else $error("accepted request produced no response");

  // A refused connect never reports a channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && busy_q) |-> (assigned_q == '0 && !accepted_q && !tx_valid_q))
    else $error("refused connect carries other response fields");

  // An acknowledge answers with either a vector or the autovector, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && autovec_q) |-> (ack_vector_q == '0))
    else $error("autovector with a vector");

  // The interrupt line shows either nothing or the configured level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (irq_line_q == '0 || irq_line_q == irq_level_q))
    else $error("interrupt line at an unexpected level");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the eight-channel terminal receiver/transmitter.
module tb_top;
  import mctu_pkg::*;

  // Op codes that the block has no use for; they must leave every flag alone.
  localparam logic [OpW-1:0]  OpSpareLo = 3'd6;
  localparam logic [OpW-1:0]  OpSpareHi = 3'd7;
  // A window offset that maps to no register.
  localparam logic [OffW-1:0] OffUnused = 3'd7;
  // Width of one packed request.
  localparam int unsigned     ReqW      = $bits(req_t);

  // One response, laid out field by field as the response channel carries it.
  typedef struct packed {
    logic [ByteW-1:0]  read_data;
    logic              accepted;
    logic [ChanW-1:0]  assigned_channel;
    logic              lines_busy;
    logic              tx_valid;
    logic [ByteW-1:0]  tx_byte;
    logic [ChanW-1:0]  tx_channel;
    logic [LevelW-1:0] irq_line;
    logic [ByteW-1:0]  ack_vector;
    logic              ack_autovector;
  } term_rsp_t;

  // A row of the directed table. Where pinned is set, the response is typed
  // in by hand; otherwise the terminal model works it out.
  typedef struct {
    req_t      stim;
    bit        pinned;
    term_rsp_t want;
  } dir_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mctu_req_if req_if ();
  mctu_rsp_if rsp_if ();
  mctu_cfg_if cfg_if ();

  multi_channel_terminal_uart_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Our own copy of the terminal state, advanced once per accepted request,
  // and of the two registers, advanced once per accepted register write.
  bit                line_up      [NumChannels];
  bit                byte_waiting [NumChannels];
  logic [ByteW-1:0]  held_byte    [NumChannels] = '{default: '0};
  bit                after_cr     [NumChannels];
  logic [LevelW-1:0] shared_level = IrqLevelReset;
  logic [ByteW-1:0]  vec_base     = VectorBaseReset;

  // Responses still owed by the block, oldest first.
  term_rsp_t   pending_rsp [$];
  dir_row_t    dir_tab [$];
  int unsigned mismatch_count = 0;
  int unsigned rsp_seen = 0;

  // Chances, in percent, of a gap before a request and of a stall per cycle
  // on the response side. Both change from phase to phase.
  int idle_pct  = 30;
  int stall_pct = 15;

  function automatic int lowest_ready();
    for (int i = 0; i < NumChannels; i++) begin
      if (byte_waiting[i]) return i;
    end
    return -1;
  endfunction

  // Applies one request to the terminal state and returns the response that
  // the block ought to give for it.
  function automatic term_rsp_t predict_rsp(req_t r);
    term_rsp_t o;
    int        slot;
    bit        here;
    o    = '0;
    here = r.channel < NumChannels;
    case (r.op)
      OpConnect: begin
        slot = -1;
        for (int i = NumChannels - 1; i >= 0; i--) begin
          if (!line_up[i]) slot = i;
        end
        if (slot >= 0) begin
          line_up[slot]      = 1'b1;
          after_cr[slot]     = 1'b0;
          o.assigned_channel = ChanW'(slot);
        end else begin
          o.lines_busy = 1'b1;
        end
      end
      OpHostByte: begin
        if (here && line_up[r.channel] && !byte_waiting[r.channel]) begin
          // An LF straight after a CR is swallowed but still counts as taken.
          if (r.data_byte == ChLf && after_cr[r.channel]) begin
            after_cr[r.channel] = 1'b0;
          end else begin
            after_cr[r.channel]     = (r.data_byte == ChCr);
            held_byte[r.channel]    = r.data_byte;
            byte_waiting[r.channel] = 1'b1;
          end
          o.accepted = 1'b1;
        end
      end
      OpDisconnect: begin
        if (here) begin
          line_up[r.channel]      = 1'b0;
          byte_waiting[r.channel] = 1'b0;
          after_cr[r.channel]     = 1'b0;
        end
      end
      OpBusRead: begin
        if (here && r.reg_offset == OffStatus) begin
          o.read_data = StAlways | (byte_waiting[r.channel] ? StRxReady : '0);
        end else if (here && r.reg_offset == OffRxData) begin
          byte_waiting[r.channel] = 1'b0;
          o.read_data             = held_byte[r.channel];
        end
      end
      OpBusWrite: begin
        if (here && r.reg_offset == OffTx && line_up[r.channel]) begin
          o.tx_valid   = 1'b1;
          o.tx_byte    = r.data_byte;
          o.tx_channel = r.channel;
        end
      end
      OpIrqAck: begin
        slot = lowest_ready();
        if (slot >= 0 && r.ack_level == shared_level) begin
          o.ack_vector = vec_base + ByteW'(slot);
        end else begin
          o.ack_autovector = 1'b1;
        end
      end
      default: begin
      end
    endcase
    o.irq_line = (lowest_ready() >= 0) ? shared_level : '0;
    return o;
  endfunction

  function automatic dir_row_t stim_row(logic [OpW-1:0] op, logic [ChanW-1:0] ch,
                                        logic [OffW-1:0] off, logic [ByteW-1:0] data,
                                        logic [LevelW-1:0] lvl, bit pin = 1'b0,
                                        term_rsp_t want = '0);
    dir_row_t row;
    row.stim   = '{op: op, channel: ch, reg_offset: off, data_byte: data, ack_level: lvl};
    row.pinned = pin;
    row.want   = want;
    return row;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("tb_top: mismatch at response %0d: %s", rsp_seen, what);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Presents one request, possibly after a random gap, and holds it until the
  // block takes it. Valid is left high, so the caller must follow at once with
  // another request, a gap or a drop of valid.
  task automatic send_req(req_t r, bit pinned = 1'b0, term_rsp_t want = '0);
    term_rsp_t guess;
    if ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= r.op;
    req_if.channel    <= r.channel;
    req_if.reg_offset <= r.reg_offset;
    req_if.data_byte  <= r.data_byte;
    req_if.ack_level  <= r.ack_level;
    do @(posedge clk); while (!req_if.ready);
    guess = predict_rsp(r);
    pending_rsp.push_back(pinned ? want : guess);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] word);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == RegIrqLevel) shared_level = word[LevelW-1:0];
    else if (idx == RegVectorBase) vec_base = word;
  endtask

  // Waits for the block to drain, then sets both registers and pokes an
  // unmapped index, which must be ignored. The level goes in with random
  // upper bits that the block has to discard.
  task automatic retune(logic [LevelW-1:0] lvl, logic [ByteW-1:0] base);
    logic [CfgDataW-1:0] noise;
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    noise = CfgDataW'($urandom);
    cfg_write(RegIrqLevel, {noise[CfgDataW-1:LevelW], lvl});
    cfg_write(RegVectorBase, base);
    cfg_write(CfgIdxW'($urandom_range(RegVectorBase + 1, 255)), noise);
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic. Most requests address channels that are connected, and
  // host bytes lean towards CR and LF, so that the latch, the CR memory and
  // the interrupt logic all see plenty of work.
  task automatic run_phase(int count, bit calm);
    req_t r;
    int   p;
    int   up_q [$];
    case ($urandom_range(0, 2))
      0:       idle_pct = 0;
      1:       idle_pct = 10;
      default: idle_pct = 35;
    endcase
    if (calm) idle_pct = 0;
    stall_pct = idle_pct / 2;
    for (int n = 0; n < count; n++) begin
      r    = req_t'(ReqW'($urandom));
      p    = $urandom_range(0, 99);
      up_q = {};
      for (int i = 0; i < NumChannels; i++) begin
        if (line_up[i]) up_q.push_back(i);
      end
      if (up_q.size() != 0 && $urandom_range(0, 9) < 7) begin
        r.channel = ChanW'(up_q[$urandom_range(0, up_q.size() - 1)]);
      end
      if (p < 12) begin
        r.op = OpConnect;
      end else if (p < 42) begin
        r.op = OpHostByte;
        case ($urandom_range(0, 3))
          0:       r.data_byte = ChCr;
          1:       r.data_byte = ChLf;
          default: r.data_byte = ByteW'($urandom);
        endcase
      end else if (p < 50) begin
        r.op = OpDisconnect;
      end else if (p < 75) begin
        r.op = OpBusRead;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r.reg_offset = OffStatus;
          4, 5, 6, 7: r.reg_offset = OffRxData;
          default:    r.reg_offset = OffW'($urandom);
        endcase
      end else if (p < 87) begin
        r.op = OpBusWrite;
        if ($urandom_range(0, 4) != 0) r.reg_offset = OffTx;
      end else if (p < 97) begin
        r.op = OpIrqAck;
        if ($urandom_range(0, 9) < 7) r.ack_level = shared_level;
      end else begin
        r.op = (p < 98) ? OpSpareLo : OpSpareHi;
      end
      send_req(r);
    end
  endtask

  // Response side: random stall bursts while a phase allows them.
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // Every response taken is held against the oldest one still owed.
  always @(posedge clk) begin : watch_rsp
    term_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = pending_rsp.pop_front();
        check_field("read_data", rsp_if.read_data, want.read_data);
        check_field("accepted", ByteW'(rsp_if.accepted), ByteW'(want.accepted));
        check_field("assigned_channel", ByteW'(rsp_if.assigned_channel),
                    ByteW'(want.assigned_channel));
        check_field("lines_busy", ByteW'(rsp_if.lines_busy), ByteW'(want.lines_busy));
        check_field("tx_valid", ByteW'(rsp_if.tx_valid), ByteW'(want.tx_valid));
        check_field("tx_byte", rsp_if.tx_byte, want.tx_byte);
        check_field("tx_channel", ByteW'(rsp_if.tx_channel), ByteW'(want.tx_channel));
        check_field("irq_line", ByteW'(rsp_if.irq_line), ByteW'(want.irq_line));
        check_field("ack_vector", rsp_if.ack_vector, want.ack_vector);
        check_field("ack_autovector", ByteW'(rsp_if.ack_autovector),
                    ByteW'(want.ack_autovector));
      end
    end
  end

  initial begin
    req_if.valid      <= 1'b0;
    req_if.op         <= '0;
    req_if.channel    <= '0;
    req_if.reg_offset <= '0;
    req_if.data_byte  <= '0;
    req_if.ack_level  <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the registers at their reset values. Nothing
    // is ready at first, so an acknowledge must autovector.
    dir_tab.push_back(stim_row(OpIrqAck, 3'd0, OffStatus, 8'h00, IrqLevelReset, 1'b1,
                               '{ack_autovector: 1'b1, default: '0}));
    dir_tab.push_back(stim_row(OpBusRead, 3'd0, OffStatus, 8'h00, 3'd0, 1'b1,
                               '{read_data: StAlways, default: '0}));
    // A host byte on a free channel is refused; then channel 0 is handed out.
    dir_tab.push_back(stim_row(OpHostByte, 3'd0, OffStatus, 8'h41, 3'd0, 1'b1, '0));
    dir_tab.push_back(stim_row(OpConnect, 3'd0, OffStatus, 8'h00, 3'd0, 1'b1, '0));
    // CR is latched; an LF while the latch is full is refused; once the CR
    // is read out, the LF that follows is swallowed and the next one kept.
    dir_tab.push_back(stim_row(OpHostByte, 3'd0, OffStatus, ChCr, 3'd0));
    dir_tab.push_back(stim_row(OpHostByte, 3'd0, OffStatus, ChLf, 3'd0));
    dir_tab.push_back(stim_row(OpBusRead, 3'd0, OffStatus, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpBusRead, 3'd0, OffRxData, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpHostByte, 3'd0, OffStatus, ChLf, 3'd0));
    dir_tab.push_back(stim_row(OpHostByte, 3'd0, OffStatus, ChLf, 3'd0));
    // Acknowledge at the right level gives the vector of channel 0; at level
    // 0 it autovectors, and the ready flag stays put either way.
    dir_tab.push_back(stim_row(OpIrqAck, 3'd0, OffStatus, 8'h00, IrqLevelReset, 1'b1,
                               '{ack_vector: VectorBaseReset, irq_line: IrqLevelReset,
                                 default: '0}));
    dir_tab.push_back(stim_row(OpIrqAck, 3'd0, OffStatus, 8'h00, 3'd0, 1'b1,
                               '{ack_autovector: 1'b1, irq_line: IrqLevelReset,
                                 default: '0}));
    dir_tab.push_back(stim_row(OpBusWrite, 3'd0, OffTx, 8'hFF, 3'd0, 1'b1,
                               '{tx_valid: 1'b1, tx_byte: 8'hFF, tx_channel: 3'd0,
                                 irq_line: IrqLevelReset, default: '0}));
    // A transmit to a free channel goes nowhere.
    dir_tab.push_back(stim_row(OpBusWrite, 3'd5, OffTx, 8'h00, 3'd0));
    for (int i = 1; i < NumChannels; i++) begin
      dir_tab.push_back(stim_row(OpConnect, 3'd0, OffStatus, 8'h00, 3'd0));
    end
    // Every line taken: the next connect is turned away.
    dir_tab.push_back(stim_row(OpConnect, 3'd0, OffStatus, 8'h00, 3'd0, 1'b1,
                               '{lines_busy: 1'b1, irq_line: IrqLevelReset, default: '0}));
    dir_tab.push_back(stim_row(OpHostByte, 3'd7, OffStatus, 8'hFF, 3'd0));
    dir_tab.push_back(stim_row(OpBusWrite, 3'd7, OffUnused, 8'hAA, 3'd0));
    // Disconnect drops the ready flag but the latch keeps its byte, which a
    // data read still returns.
    dir_tab.push_back(stim_row(OpDisconnect, 3'd0, OffStatus, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpBusRead, 3'd0, OffRxData, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpBusRead, 3'd7, OffUnused, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpConnect, 3'd0, OffStatus, 8'h00, 3'd0));
    dir_tab.push_back(stim_row(OpSpareLo, 3'd7, OffUnused, 8'hFF, 3'd7));
    dir_tab.push_back(stim_row(OpSpareHi, 3'd7, OffUnused, 8'hFF, 3'd7));
    foreach (dir_tab[i]) send_req(dir_tab[i].stim, dir_tab[i].pinned, dir_tab[i].want);

    // Random part over several register settings: the top level with the
    // highest base, so that channel 7 lands on vector 255; the lowest non-zero level
    // with base zero; level 0, which never raises the line, with a base that
    // wraps; then random settings, the last of them without any idling.
    retune(3'd7, 8'd248);
    run_phase(60, 1'b0);
    retune(3'd1, 8'd0);
    run_phase(60, 1'b0);
    retune(3'd0, 8'd255);
    run_phase(50, 1'b0);
    repeat (3) begin
      retune(LevelW'($urandom_range(1, 7)), ByteW'($urandom_range(0, 248)));
      run_phase(70, 1'b0);
    end
    retune(LevelW'($urandom_range(1, 7)), ByteW'($urandom_range(0, 248)));
    run_phase(70, 1'b1);

    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Far beyond the slowest correct run, stalls and gaps included.
  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
